// ===== src/grr_pkg.sv =====
package grr_pkg;

  localparam int MAX_FINE_SIDE_DEF = 1025;
  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int CFG_SIDE_W        = 11;
  localparam int CFG_IDX_W         = 1;
  localparam int COORD_W           = 10;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [CFG_SIDE_W-1:0] SIDE_RESET = CFG_SIDE_W'(1025);
  localparam logic                  MODE_RESET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FINE_SIDE_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MODE   = CFG_IDX_W'(1);

  typedef enum logic {
    OP_PASS  = 1'b0,
    OP_WEIGH = 1'b1
  } grr_op_t;

  typedef struct packed {
    grr_op_t              op;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic                 last;
  } grr_tag_t;

endpackage

// ===== src/grid_restriction_2d.sv =====
// grid_restriction_2d: 2-D restriction of an odd-sided square grid to its coarse grid.
// Input channel (in_valid/in_ready/in_fine_sample): one fine sample per beat, raster
// order, signed Q16.16. Output channel (out_valid/out_ready, out_coarse_*): one coarse
// sample per beat, raster order, with out_last_of_grid on the final coarse sample.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready; index 0 sets
// the fine side, index 1 the mode (0 injection, 1 full weighting). Any write restarts
// the grid at fine sample (0,0); the line buffers keep their contents.
// Throughput: one fine sample per cycle while in_ready is high, bounded by one line
// buffer read and one line buffer write per cycle. A result passes from the fine sample
// that completes it through the s1 registers and the queue into the output register.
// Reset (synchronous, rst_n low): side 1025, full weighting, counters at the grid
// start, queue and output register empty; no clearing pass is needed.
// When the receiver stalls, results collect in a 4-entry queue behind the output
// register and in_ready drops once that queue, counting the sample in flight, is full.
module grid_restriction_2d import grr_pkg::*; #(
  parameter int MAX_FINE_SIDE = MAX_FINE_SIDE_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_fine_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_coarse_value,
  output logic [COORD_W-1:0]             out_coarse_row,
  output logic [COORD_W-1:0]             out_coarse_col,
  output logic                           out_last_of_grid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_SIDE_W-1:0]          cfg_data
);

  localparam int CS_W   = SAMPLE_WIDTH + 2;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH+1);
  localparam int ENTRY_W = $bits(grr_tag_t) + 3 * CS_W;

  logic                    push;
  grr_tag_t                push_tag;
  logic [2:0][CS_W-1:0]    push_ops;
  logic                    pop;
  logic                    head_valid;
  grr_tag_t                head_tag;
  logic [2:0][CS_W-1:0]    head_ops;
  logic [ENTRY_W-1:0]      q_din;
  logic [ENTRY_W-1:0]      q_dout;
  logic [CNT_W-1:0]        q_count;

  grr_front #(
    .MAX_FINE_SIDE (MAX_FINE_SIDE),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_fine_sample (in_fine_sample),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_count        (q_count),
    .push           (push),
    .push_tag       (push_tag),
    .push_ops       (push_ops)
  );

  assign q_din = {push_tag, push_ops};

  grr_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .din        (q_din),
    .pop        (pop),
    .head_valid (head_valid),
    .dout       (q_dout),
    .count      (q_count)
  );

  assign {head_tag, head_ops} = q_dout;

  grr_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_tag         (head_tag),
    .head_ops         (head_ops),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coarse_value (out_coarse_value),
    .out_coarse_row   (out_coarse_row),
    .out_coarse_col   (out_coarse_col),
    .out_last_of_grid (out_last_of_grid)
  );

endmodule

// ===== src/grr_fifo.sv =====
module grr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [WIDTH-1:0]           dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  assign head_valid = (count_r != '0);
  assign dout       = slot_r[rd_ptr_r];
  assign count      = count_r;

endmodule

// ===== src/grr_front.sv =====
module grr_front import grr_pkg::*; #(
  parameter int MAX_FINE_SIDE = MAX_FINE_SIDE_DEF,
  parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]              in_fine_sample,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]                        cfg_index,
  input  logic [CFG_SIDE_W-1:0]                       cfg_data,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]            q_count,
  output logic                                        push,
  output grr_tag_t                                    push_tag,
  output logic [2:0][SAMPLE_WIDTH+1:0]                push_ops
);

  localparam int AW       = $clog2(MAX_FINE_SIDE);
  localparam int SW       = SAMPLE_WIDTH;
  localparam int CS_W     = SAMPLE_WIDTH + 2;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH+1);
  localparam int SIDE_CAP = (MAX_FINE_SIDE - 1) | 1;

  typedef struct packed {
    logic [SW-1:0] older;
    logic [SW-1:0] newer;
  } line_t;

  function automatic logic [AW-1:0] side_m1(input logic [CFG_SIDE_W-1:0] len);
    int n;
    n = int'(len) | 1;
    if (n < 3) n = 3;
    if (n > SIDE_CAP) n = SIDE_CAP;
    return AW'(n - 1);
  endfunction

  line_t line_mem [MAX_FINE_SIDE];
  line_t rd_q_r;

  logic [AW-1:0]          nm1_r;
  logic                   mode_r;
  logic [AW-1:0]          row_r, row_nxt;
  logic [AW-1:0]          col_r, col_nxt;
  logic                   s1_v_r;
  logic signed [SW-1:0]   s1_x_r;
  logic [AW-1:0]          s1_row_r;
  logic [AW-1:0]          s1_col_r;
  logic signed [CS_W-1:0] cs1_r, cs2_r;
  logic [SW-1:0]          new1_r;

  logic                   in_acc;
  logic                   cfg_acc;
  logic signed [CS_W-1:0] cs_cur;
  logic signed [CS_W-1:0] pass_val;
  logic                   inj_row;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = s1_v_r ? (q_count < CNT_W'(QUEUE_DEPTH - 1))
                            : (q_count < CNT_W'(QUEUE_DEPTH));
  assign in_acc    = in_valid && in_ready;

  // raster counters
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (in_acc) begin
      if (col_r == nm1_r) begin
        col_nxt = '0;
        row_nxt = (row_r == nm1_r) ? '0 : row_r + AW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm1_r  <= side_m1(SIDE_RESET);
      mode_r <= MODE_RESET;
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      if (cfg_acc) begin
        row_r <= '0;
        col_r <= '0;
        unique case (cfg_index)
          REG_FINE_SIDE_LEN: nm1_r  <= side_m1(cfg_data);
          REG_WEIGHT_MODE:   mode_r <= cfg_data[0];
          default: ;
        endcase
      end else begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q_r   <= line_mem[col_r];
      s1_x_r   <= in_fine_sample;
      s1_row_r <= row_r;
      s1_col_r <= col_r;
    end
  end

  // line buffer rotation and column window
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_mem[s1_col_r] <= '{older: rd_q_r.newer, newer: s1_x_r};
      cs2_r  <= cs1_r;
      cs1_r  <= cs_cur;
      new1_r <= rd_q_r.newer;
    end
  end

  assign cs_cur = CS_W'($signed(rd_q_r.older)) + (CS_W'($signed(rd_q_r.newer)) <<< 1)
                + CS_W'(s1_x_r);

  always_comb begin
    inj_row         = !mode_r || (s1_row_r == '0) || (s1_row_r == nm1_r);
    push            = 1'b0;
    pass_val        = CS_W'(s1_x_r);
    push_tag.op     = OP_PASS;
    push_tag.row    = COORD_W'(s1_row_r >> 1);
    push_tag.col    = COORD_W'(s1_col_r >> 1);
    push_tag.last   = (s1_row_r == nm1_r) && (s1_col_r == nm1_r);
    priority if (inj_row) begin
      push = !s1_row_r[0] && !s1_col_r[0];
    end else if (s1_row_r[0] && (s1_row_r >= AW'(3))) begin
      if (s1_col_r == nm1_r) begin
        push     = 1'b1;
        pass_val = CS_W'($signed(rd_q_r.newer));
      end else if (s1_col_r[0]) begin
        push = 1'b1;
        if (s1_col_r == AW'(1)) begin
          pass_val = CS_W'($signed(new1_r));
        end else begin
          push_tag.op = OP_WEIGH;
          pass_val    = cs2_r;
        end
      end
    end else begin
      push = 1'b0;
    end
    push = push && s1_v_r;
    push_ops[0] = pass_val;
    push_ops[1] = cs1_r;
    push_ops[2] = cs_cur;
  end

endmodule

// ===== src/grr_back.sv =====
module grr_back import grr_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  grr_tag_t                      head_tag,
  input  logic [2:0][SAMPLE_WIDTH+1:0]  head_ops,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_coarse_value,
  output logic [COORD_W-1:0]            out_coarse_row,
  output logic [COORD_W-1:0]            out_coarse_col,
  output logic                          out_last_of_grid
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int ACC_W = SAMPLE_WIDTH + 5;

  logic                 out_valid_r;
  logic [SW-1:0]        value_r;
  logic [COORD_W-1:0]   row_r;
  logic [COORD_W-1:0]   col_r;
  logic                 last_r;

  logic [ACC_W-1:0]     acc;
  logic [SW-1:0]        value_nxt;

  // 1-2-1 across three column sums, plus rounding half up, then divide by 16
  always_comb begin
    acc = ACC_W'($signed(head_ops[0])) + (ACC_W'($signed(head_ops[1])) << 1)
        + ACC_W'($signed(head_ops[2])) + ACC_W'(8);
    unique case (head_tag.op)
      OP_WEIGH: value_nxt = acc[SW+3:4];
      OP_PASS:  value_nxt = head_ops[0][SW-1:0];
      default:  value_nxt = head_ops[0][SW-1:0];
    endcase
  end

  assign pop = head_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value_r <= value_nxt;
      row_r   <= head_tag.row;
      col_r   <= head_tag.col;
      last_r  <= head_tag.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coarse_value = value_r;
  assign out_coarse_row   = row_r;
  assign out_coarse_col   = col_r;
  assign out_last_of_grid = last_r;

endmodule
